>>> rtl/core/tsc_pkg.sv
// turn signal controller package: frame and result structs, codes and reset values
// no dependencies; imported by every module of the block
`default_nettype none

package tsc_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 2;

  // button codes
  localparam logic [CodeW-1:0] BTN_NONE   = 2'd0;
  localparam logic [CodeW-1:0] BTN_LEFT   = 2'd1;
  localparam logic [CodeW-1:0] BTN_RIGHT  = 2'd2;
  localparam logic [CodeW-1:0] BTN_HAZARD = 2'd3;

  // signal mode / lamp codes share the button encoding
  localparam logic [CodeW-1:0] MODE_OFF   = BTN_NONE;
  localparam logic [CodeW-1:0] MODE_LEFT  = BTN_LEFT;
  localparam logic [CodeW-1:0] MODE_RIGHT = BTN_RIGHT;

  // configuration register indexes
  localparam logic [1:0] CFG_LEFT_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_BLINK_PERIOD    = 2'd2;

  // reset values
  localparam logic [ByteW-1:0] LEFT_THRESHOLD_RST  = 8'd87;
  localparam logic [ByteW-1:0] RIGHT_THRESHOLD_RST = 8'd67;
  localparam logic [ByteW-1:0] BLINK_PERIOD_RST    = 8'd25;
  localparam logic [ByteW-1:0] LAST_WHEEL_RST      = 8'd75;

  typedef struct packed {
    logic [ByteW-1:0] wheel_angle;
    logic [ByteW-1:0] throttle;
    logic [ByteW-1:0] brake;
    logic [CodeW-1:0] blink_button;
  } frame_t;

  typedef struct packed {
    logic [ByteW-1:0] wheel_out;
    logic [ByteW-1:0] throttle_out;
    logic [ByteW-1:0] brake_out;
    logic [CodeW-1:0] lamp_code;
  } result_t;

  // handshake between the input stage and the result stage
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/turn_signal_controller.sv
// turn signal controller top level: input stage, signal core, result stage
// depends on tsc_pkg, tsc_in_stage, tsc_signal_core, tsc_out_stage
//
// channel  direction  handshake                   payload
// in       consumer   in_valid_i / in_stall_o     in_frame_i   (frame_t)
// out      producer   out_valid_o / out_stall_i   out_result_o (result_t)
// cfg      write      cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// one frame per cycle while out is not stalled; out_valid_o rises once the frame has passed
// through the input register and then the result register
// the signal state updates as a frame moves into the result register
// reset clears handshake state, signal state, and loads the default thresholds/period
// a stall on out propagates to in_stall_o only once both registers hold frames
`default_nettype none

module turn_signal_controller
  import tsc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire frame_t           in_frame_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output result_t               out_result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [ByteW-1:0] cfg_wdata_i
);

  stage_ctrl_t      ctrl;
  frame_t           frame;
  logic             take;
  logic [CodeW-1:0] lamp_code;

  tsc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_frame_i (in_frame_i),
    .take_i     (take),
    .ctrl_o     (ctrl),
    .frame_o    (frame)
  );

  tsc_signal_core u_signal_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .frame_i     (frame),
    .lamp_code_o (lamp_code)
  );

  tsc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .frame_i      (frame),
    .lamp_code_i  (lamp_code),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/tsc_in_stage.sv
// input register for control frames, with valid/stall handshake
// depends on tsc_pkg
`default_nettype none

module tsc_in_stage
  import tsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire frame_t      in_frame_i,
  input  wire logic        take_i,
  output stage_ctrl_t      ctrl_o,
  output frame_t           frame_o
);

  logic   valid_q, valid_d;
  frame_t frame_q;
  logic   accept;

  // stall only while holding a frame the next stage cannot take
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, loaded on input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= in_frame_i;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign ctrl_o.take  = take_i;
  assign frame_o      = frame_q;

endmodule

`default_nettype wire

>>> rtl/core/tsc_signal_core.sv
// turn signal state: config registers, button edge, self-cancel and blink counter
// depends on tsc_pkg
`default_nettype none

module tsc_signal_core
  import tsc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [ByteW-1:0]  cfg_wdata_i,
  input  wire stage_ctrl_t       ctrl_i,
  input  wire frame_t            frame_i,
  output logic [CodeW-1:0]       lamp_code_o
);

  logic [ByteW-1:0] left_thr_q, right_thr_q, period_q;
  logic [CodeW-1:0] held_q, held_d;
  logic [CodeW-1:0] mode_q, mode_d;
  logic [ByteW-1:0] last_wheel_q;
  logic [ByteW-1:0] tick_q, tick_d;
  logic [CodeW-1:0] lamp_q, lamp_d;
  logic             fire;

  logic [CodeW-1:0] btn;
  logic [ByteW-1:0] wheel;
  logic [CodeW-1:0] mode_p, lamp_p;
  logic [CodeW-1:0] mode_c, lamp_c;
  logic [ByteW-1:0] tick_inc;

  assign fire  = ctrl_i.valid && ctrl_i.take;
  assign btn   = frame_i.blink_button;
  assign wheel = frame_i.wheel_angle;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_thr_q  <= LEFT_THRESHOLD_RST;
      right_thr_q <= RIGHT_THRESHOLD_RST;
      period_q    <= BLINK_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT_THRESHOLD:  left_thr_q  <= cfg_wdata_i;
        CFG_RIGHT_THRESHOLD: right_thr_q <= cfg_wdata_i;
        CFG_BLINK_PERIOD:    period_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // button press edge
  always_comb begin
    held_d = held_q;
    mode_p = mode_q;
    lamp_p = lamp_q;
    if (held_q == BTN_NONE && btn != BTN_NONE) begin
      held_d = btn;
      if (mode_q == MODE_LEFT && btn == BTN_RIGHT) begin
        mode_p = MODE_RIGHT;
        lamp_p = MODE_RIGHT;
      end else if (mode_q == MODE_LEFT && btn == BTN_LEFT) begin
        mode_p = MODE_OFF;
      end else if (mode_q == MODE_RIGHT && btn == BTN_LEFT) begin
        mode_p = MODE_LEFT;
        lamp_p = MODE_LEFT;
      end else if (mode_q == MODE_RIGHT && btn == BTN_RIGHT) begin
        mode_p = MODE_OFF;
      end else begin
        mode_p = btn;
        lamp_p = btn;
      end
    end else if (held_q != BTN_NONE && btn == BTN_NONE) begin
      held_d = BTN_NONE;
    end
  end

  // self-cancel on wheel crossing, left side tested first
  always_comb begin
    mode_c = mode_p;
    lamp_c = lamp_p;
    if (mode_p == MODE_LEFT && last_wheel_q >= left_thr_q && wheel < left_thr_q) begin
      mode_c = MODE_OFF;
      lamp_c = MODE_OFF;
    end else if (mode_p == MODE_RIGHT && last_wheel_q <= right_thr_q
                 && wheel > right_thr_q) begin
      mode_c = MODE_OFF;
      lamp_c = MODE_OFF;
    end
  end

  // blink counter
  assign tick_inc = tick_q + 8'd1;

  always_comb begin
    mode_d = mode_c;
    tick_d = '0;
    lamp_d = MODE_OFF;
    if (mode_c != MODE_OFF) begin
      tick_d = tick_inc;
      lamp_d = lamp_c;
      if (tick_inc >= period_q) begin
        tick_d = '0;
        lamp_d = (lamp_c == MODE_OFF) ? mode_c : MODE_OFF;
      end
    end
  end

  // state update on each frame transfer into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= BTN_NONE;
      mode_q       <= MODE_OFF;
      last_wheel_q <= LAST_WHEEL_RST;
      tick_q       <= '0;
      lamp_q       <= MODE_OFF;
    end else if (fire) begin
      held_q       <= held_d;
      mode_q       <= mode_d;
      last_wheel_q <= wheel;
      tick_q       <= tick_d;
      lamp_q       <= lamp_d;
    end
  end

  assign lamp_code_o = lamp_d;

endmodule

`default_nettype wire

>>> rtl/core/tsc_out_stage.sv
// result register with valid/stall handshake toward the consumer
// depends on tsc_pkg
`default_nettype none

module tsc_out_stage
  import tsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stage_ctrl_t ctrl_i,
  input  wire frame_t      frame_i,
  input  wire logic [CodeW-1:0] lamp_code_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output result_t          out_result_o
);

  logic    valid_q, valid_d;
  result_t result_q;
  logic    load;

  // free when empty or when the held result transfers this cycle
  assign take_o = !valid_q || !out_stall_i;
  assign load   = ctrl_i.valid && take_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q.wheel_out    <= frame_i.wheel_angle;
      result_q.throttle_out <= frame_i.throttle;
      result_q.brake_out    <= frame_i.brake;
      result_q.lamp_code    <= lamp_code_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

`default_nettype wire
